### rtl/pgw_pkg.sv
`default_nettype none

package pgw_pkg;

  localparam int TABLE_FRAMES_DEF = 16;
  localparam int ENTRY_IDX_W      = 9;
  localparam int ROOT_W           = 4;
  localparam int PTE_W            = 64;
  localparam int PFN_W            = 40;
  localparam int PFN_LSB          = 12;
  localparam int VA_W             = 64;

  localparam int PTE_P   = 0;
  localparam int PTE_RW  = 1;
  localparam int PTE_US  = 2;
  localparam int PTE_PCD = 4;
  localparam int PTE_PS  = 7;
  localparam int PTE_NX  = 63;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADADDR = 2'd1,
    ST_FAIL    = 2'd2,
    ST_WRITTEN = 2'd3
  } pgw_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_WALK,
    S_RESP
  } pgw_state_t;

  typedef struct packed {
    logic                   func;
    logic [3:0]             table_frame;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [PTE_W-1:0]       entry_data;
    logic [VA_W-1:0]        lin_addr;
  } pgw_in_t;

  typedef struct packed {
    pgw_status_t      status;
    logic [PFN_W-1:0] frame_number;
    logic             writable;
    logic             user_access;
    logic             executable;
    logic             uncached;
  } pgw_out_t;

endpackage

`default_nettype wire

### rtl/pgw_ram.sv
`default_nettype none

module pgw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/four_level_page_table_walker.sv
`default_nettype none

// Four-level page table walker for 4 KiB pages. The table store holds TABLE_FRAMES tables of
// 512 64-bit entries in one single-port-write, single-port-read RAM with registered read.
// After reset the block sweeps the store to zero, one entry per cycle, all TABLE_FRAMES*512
// entries (8192 at the default), and accepts no transaction meanwhile; cfg writes are taken at
// any time. One transaction is handled at a time. A write transaction writes its entry in the
// start state and then holds its result until it is taken with out_ready high. A translate
// transaction costs one RAM read per level, each dependent on the previous entry, so a full
// walk reads four entries; an address fault or an early walk failure returns sooner.

module four_level_page_table_walker #(
  parameter int TABLE_FRAMES = pgw_pkg::TABLE_FRAMES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire pgw_pkg::pgw_in_t          in_data,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      pgw_pkg::pgw_out_t         out_data,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [pgw_pkg::ROOT_W-1:0] cfg_data
);

  import pgw_pkg::*;

  localparam int DEPTH   = TABLE_FRAMES * 512;
  localparam int FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int ADDR_W  = FRAME_W + ENTRY_IDX_W;

  pgw_state_t state_r, state_nxt;

  logic [ROOT_W-1:0] root_r;
  pgw_in_t           req_r, req_nxt;
  pgw_out_t          res_r, res_nxt;
  logic [1:0]        level_r, level_nxt;
  logic              wr_acc_r, wr_acc_nxt;
  logic              us_acc_r, us_acc_nxt;
  logic              nx_acc_r, nx_acc_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PTE_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [PTE_W-1:0]  ram_rdata;

  logic              in_fire;
  logic              clr_done;
  logic [PFN_W-1:0]  root_ext;
  logic [PFN_W-1:0]  wframe_ext;
  logic              wframe_ok;
  logic              va_bad;
  logic              no_map;
  logic              root_bad;
  logic              pre_fail;
  logic [PFN_W-1:0]  ent_pfn;
  logic              ent_absent;
  logic              ent_bad;
  logic              last_level;

  function automatic logic [ENTRY_IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                      input logic [1:0] lvl);
    logic [ENTRY_IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

  pgw_ram #(
    .WIDTH(PTE_W),
    .DEPTH(DEPTH)
  ) u_table_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_data  = res_r;
  assign clr_done  = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  assign root_ext   = PFN_W'(root_r);
  assign wframe_ext = PFN_W'(req_r.table_frame);
  assign wframe_ok  = (wframe_ext < PFN_W'(TABLE_FRAMES));
  assign no_map     = (root_r == '0);
  assign root_bad   = (root_ext >= PFN_W'(TABLE_FRAMES));
  assign va_bad     = (req_r.lin_addr[11:0] != 12'd0) ||
                      ((req_r.lin_addr[63:47] != '0) &&
                       (req_r.lin_addr[63:47] != '1));
  assign pre_fail   = no_map || va_bad || root_bad;

  assign ent_pfn    = ram_rdata[PFN_LSB +: PFN_W];
  assign last_level = (level_r == 2'd3);
  assign ent_absent = !ram_rdata[PTE_P];
  assign ent_bad    = ent_absent ||
                      (!last_level && (ram_rdata[PTE_PS] || (ent_pfn == '0) ||
                                       (ent_pfn >= PFN_W'(TABLE_FRAMES))));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (req_r.func == FUNC_WRITE || pre_fail) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (ent_bad || last_level) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = {root_ext[FRAME_W-1:0], va_index(req_r.lin_addr, 2'd0)};
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_START: begin
        if (req_r.func == FUNC_WRITE) begin
          ram_we    = wframe_ok;
          ram_waddr = {wframe_ext[FRAME_W-1:0], req_r.entry_index};
          ram_wdata = req_r.entry_data;
        end else begin
          ram_re = !pre_fail;
        end
      end
      S_WALK: begin
        ram_re    = !ent_bad && !last_level;
        ram_raddr = {ent_pfn[FRAME_W-1:0],
                     va_index(req_r.lin_addr, level_r + 2'd1)};
      end
      S_RESP: begin
        out_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    req_nxt     = req_r;
    res_nxt     = res_r;
    level_nxt   = level_r;
    wr_acc_nxt  = wr_acc_r;
    us_acc_nxt  = us_acc_r;
    nx_acc_nxt  = nx_acc_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          req_nxt = in_data;
        end
      end
      S_START: begin
        res_nxt    = '0;
        level_nxt  = 2'd0;
        wr_acc_nxt = 1'b1;
        us_acc_nxt = 1'b1;
        nx_acc_nxt = 1'b0;
        if (req_r.func == FUNC_WRITE) begin
          res_nxt.status = ST_WRITTEN;
        end else if (no_map) begin
          res_nxt.status = ST_FAIL;
        end else if (va_bad) begin
          res_nxt.status = ST_BADADDR;
        end else if (root_bad) begin
          res_nxt.status = ST_FAIL;
        end
      end
      S_WALK: begin
        wr_acc_nxt = wr_acc_r & ram_rdata[PTE_RW];
        us_acc_nxt = us_acc_r & ram_rdata[PTE_US];
        nx_acc_nxt = nx_acc_r | ram_rdata[PTE_NX];
        level_nxt  = level_r + 2'd1;
        if (ent_bad) begin
          res_nxt        = '0;
          res_nxt.status = ST_FAIL;
        end else if (last_level) begin
          res_nxt.status       = ST_OK;
          res_nxt.frame_number = ent_pfn;
          res_nxt.writable     = wr_acc_r & ram_rdata[PTE_RW];
          res_nxt.user_access  = us_acc_r & ram_rdata[PTE_US];
          res_nxt.executable   = !(nx_acc_r | ram_rdata[PTE_NX]);
          res_nxt.uncached     = ram_rdata[PTE_PCD];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      root_r    <= '0;
      clr_cnt_r <= '0;
      level_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      level_r   <= level_nxt;
      if (cfg_valid && cfg_ready) begin
        root_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    res_r    <= res_nxt;
    wr_acc_r <= wr_acc_nxt;
    us_acc_r <= us_acc_nxt;
    nx_acc_r <= nx_acc_nxt;
  end

endmodule

`default_nettype wire

### tb/tb_four_level_page_table_walker.sv
`timescale 1ns / 100ps

module tb_four_level_page_table_walker;
  import pgw_pkg::*;

  localparam int NFRAMES = TABLE_FRAMES_DEF;
  localparam int IDLE_LIMIT = 30000;
  localparam logic [63:0] M_P = 64'(1) << PTE_P;
  localparam logic [63:0] M_W = 64'(1) << PTE_RW;
  localparam logic [63:0] M_U = 64'(1) << PTE_US;
  localparam logic [63:0] M_PCD = 64'(1) << PTE_PCD;
  localparam logic [63:0] M_HUGE = 64'(1) << PTE_PS;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pgw_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pgw_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ROOT_W-1:0] cfg_data = '0;

  logic [63:0] shadow_pt [0:NFRAMES*512-1];
  logic [ROOT_W-1:0] shadow_root = '0;
  pgw_in_t pend_q[$];
  pgw_out_t want_q[$];
  pgw_out_t got_want;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  four_level_page_table_walker uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic pgw_out_t walk_shadow(pgw_in_t t);
    pgw_out_t r;
    logic [63:0] va;
    logic [63:0] e;
    logic [63:0] and_e;
    logic [63:0] or_e;
    logic [39:0] fr;
    logic [8:0] idx;
    int lv;
    r = '0;
    va = t.lin_addr;
    if (t.func == FUNC_WRITE) begin
      if (t.table_frame < NFRAMES) shadow_pt[{t.table_frame, t.entry_index}] = t.entry_data;
      r.status = ST_WRITTEN;
      return r;
    end
    if (shadow_root == 0) begin
      r.status = ST_FAIL;
      return r;
    end
    if (va[11:0] != 0 || va[63:48] != {16{va[47]}}) begin
      r.status = ST_BADADDR;
      return r;
    end
    if (shadow_root >= NFRAMES) begin
      r.status = ST_FAIL;
      return r;
    end
    fr = 40'(shadow_root);
    and_e = '1;
    or_e = '0;
    e = '0;
    for (lv = 0; lv < 4; lv++) begin
      idx = va[39 - 9*lv +: 9];
      e = shadow_pt[{fr[3:0], idx}];
      and_e &= e;
      or_e |= e;
      if (!e[PTE_P]) begin
        r.status = ST_FAIL;
        return r;
      end
      if (lv < 3) begin
        fr = e[51:12];
        if (e[PTE_PS] || fr == 0 || fr >= NFRAMES) begin
          r.status = ST_FAIL;
          return r;
        end
      end
    end
    r.status = ST_OK;
    r.frame_number = e[51:12];
    r.writable = and_e[PTE_RW];
    r.user_access = and_e[PTE_US];
    r.executable = !or_e[PTE_NX];
    r.uncached = e[PTE_PCD];
    return r;
  endfunction

  function automatic pgw_in_t mk_wr(logic [3:0] f, logic [8:0] i, logic [63:0] d);
    pgw_in_t t;
    t.func = FUNC_WRITE;
    t.table_frame = f;
    t.entry_index = i;
    t.entry_data = d;
    t.lin_addr = {$urandom, $urandom};
    return t;
  endfunction

  function automatic pgw_in_t mk_tr(logic [63:0] va);
    pgw_in_t t;
    t.func = FUNC_XLATE;
    t.table_frame = 4'($urandom);
    t.entry_index = 9'($urandom);
    t.entry_data = {$urandom, $urandom};
    t.lin_addr = va;
    return t;
  endfunction

  function automatic logic [63:0] canon_va();
    logic [35:0] ix;
    ix = 36'({$urandom, $urandom});
    return {{16{ix[35]}}, ix, 12'h000};
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) want_q.push_back(walk_shadow(in_data));
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          in_data <= pend_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected transaction: status=%0d frame=%h", out_data.status,
                     out_data.frame_number);
        end else begin
          got_want = want_q.pop_front();
          if (out_data !== got_want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: exp st=%0d fr=%h w=%b u=%b x=%b pcd=%b",
                       got_want.status, got_want.frame_number, got_want.writable,
                       got_want.user_access, got_want.executable, got_want.uncached);
              $display("          got st=%0d fr=%h w=%b u=%b x=%b pcd=%b",
                       out_data.status, out_data.frame_number, out_data.writable,
                       out_data.user_access, out_data.executable, out_data.uncached);
            end
          end
        end
      end
      if (hold_cnt != 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pend_q.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_root(input logic [3:0] v);
    drain();
    repeat (4) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    shadow_root = v;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic gen_items(input int n);
    int cnt;
    int l;
    logic [63:0] va;
    logic [63:0] e;
    logic [39:0] nf;
    logic [3:0] tf;
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 9))
        0: begin
          pend_q.push_back(mk_wr(4'($urandom), 9'($urandom), {$urandom, $urandom}));
          cnt++;
        end
        1: begin
          va = canon_va();
          case ($urandom_range(0, 2))
            0: va = {$urandom, $urandom};
            1: va[11:0] = 12'($urandom_range(1, 4095));
            default: va[63:48] = va[63:48] ^ 16'($urandom_range(1, 65535));
          endcase
          pend_q.push_back(mk_tr(va));
          cnt++;
        end
        default: begin
          // build one walk, sometimes skipping a level so stale entries are used
          va = canon_va();
          tf = shadow_root;
          for (l = 0; l < 4; l++) begin
            if (l == 3) nf = 40'({$urandom, $urandom});
            else if ($urandom_range(0, 29) == 0) nf = '0;
            else if ($urandom_range(0, 29) == 0) nf = 40'({$urandom, $urandom});
            else nf = 40'($urandom_range(1, NFRAMES - 1));
            e = {$urandom, $urandom};
            e[51:12] = nf;
            e[PTE_P] = ($urandom_range(0, 19) != 0);
            e[PTE_RW] = ($urandom_range(0, 9) != 0);
            e[PTE_US] = ($urandom_range(0, 9) != 0);
            e[PTE_NX] = ($urandom_range(0, 7) == 0);
            if (l < 3) e[PTE_PS] = ($urandom_range(0, 24) == 0);
            if ($urandom_range(0, 9) != 0) begin
              pend_q.push_back(mk_wr(tf, va[39 - 9*l +: 9], e));
              cnt++;
            end
            tf = nf[3:0];
          end
          pend_q.push_back(mk_tr(va));
          cnt++;
          if ($urandom_range(0, 3) == 0) begin
            va[20:12] = 9'($urandom);
            pend_q.push_back(mk_tr(va));
            cnt++;
          end
        end
      endcase
    end
  endtask

  initial begin
    int ph;
    logic [3:0] ph_root;
    for (int i = 0; i < NFRAMES * 512; i++) shadow_pt[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_root(4'd0);
    pend_q.push_back(mk_tr(64'h0));
    pend_q.push_back(mk_tr(64'h1));
    set_root(4'd15);
    pend_q.push_back(mk_tr(64'h0));
    set_root(4'd1);
    pend_q.push_back(mk_tr(64'h1));
    pend_q.push_back(mk_tr(64'h0000_8000_0000_0000));
    pend_q.push_back(mk_tr(64'hFFFF_7FFF_FFFF_F000));
    pend_q.push_back(mk_tr(64'hFFFF_FFFF_FFFF_F000));
    pend_q.push_back(mk_wr(4'd1, 9'd511, (64'd2 << 12) | M_P | M_W | M_U));
    pend_q.push_back(mk_wr(4'd2, 9'd511, (64'd3 << 12) | M_P | M_W | M_U));
    pend_q.push_back(mk_wr(4'd3, 9'd511, (64'd15 << 12) | M_P | M_W | M_U));
    pend_q.push_back(mk_wr(4'd15, 9'd511,
                           64'h000F_FFFF_FFFF_F000 | M_P | M_W | M_U | M_PCD | M_HUGE));
    pend_q.push_back(mk_tr(64'hFFFF_FFFF_FFFF_F000));
    pend_q.push_back(mk_wr(4'd15, 9'd511, ~M_W));
    pend_q.push_back(mk_tr(64'hFFFF_FFFF_FFFF_F000));
    pend_q.push_back(mk_wr(4'd3, 9'd511, (64'd15 << 12) | M_P | M_HUGE));
    pend_q.push_back(mk_tr(64'hFFFF_FFFF_FFFF_F000));
    pend_q.push_back(mk_wr(4'd3, 9'd511, M_P));
    pend_q.push_back(mk_tr(64'hFFFF_FFFF_FFFF_F000));
    pend_q.push_back(mk_wr(4'd2, 9'd511, (64'(NFRAMES) << 12) | M_P));
    pend_q.push_back(mk_tr(64'hFFFF_FFFF_FFFF_F000));
    pend_q.push_back(mk_wr(4'd0, 9'd0, '0));
    pend_q.push_back(mk_wr(4'd0, 9'd0, '1));

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: ph_root = 4'd15;
        1: ph_root = 4'($urandom_range(2, 14));
        2: ph_root = 4'd1;
        default: ph_root = 4'($urandom_range(1, 15));
      endcase
      set_root(ph_root);
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 74; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 74; end
        default: begin snd_idle_pct = 19; rcv_stall_pct = 19; end
      endcase
      gen_items(160);
      if (ph == 0) begin
        // hold the result channel while the sender keeps offering
        while (pend_q.size() > 100) @(negedge clk);
        hold_req = 1'b1;
      end
      if (ph == 1) drain();
      gen_items(160);
    end

    drain();
    repeat (20) @(negedge clk);
    if (err_cnt == 0 && want_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
